FILE: rtl/sis_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sis_pkg
// Shared sizes, status codes and the cell control type for the sorted set.
// ----------------------------------------------------------------------------
package sis_pkg;

  localparam int DEPTH      = 64;
  localparam int VALUE_BITS = 16;
  localparam int IDX_W      = $clog2(DEPTH);
  localparam int CNT_W      = $clog2(DEPTH + 1);
  localparam int FIELD_W    = 7;

  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_REMOVE = 1'b1;

  localparam logic [1:0] ST_INSERTED  = 2'd0;
  localparam logic [1:0] ST_REMOVED   = 2'd1;
  localparam logic [1:0] ST_NOT_FOUND = 2'd2;
  localparam logic [1:0] ST_FULL      = 2'd3;

  typedef logic [VALUE_BITS-1:0] value_t;

  typedef struct packed {
    logic cmp;         // latch the per-cell compare flags
    logic shift_up;    // apply an insert
    logic shift_down;  // apply a remove
  } cell_ctrl_t;

endpackage

FILE: rtl/sorted_index_set.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_index_set
// Ascending table of index values with duplicate-friendly insert and remove.
// ----------------------------------------------------------------------------
// Input items arrive on the s_ group: s_tuser is the command (insert or
// remove) and s_tdata the value. Every item yields one result item on the m_
// group: m_tuser is the status, m_tdata the slot and the count after the item.
// An insert goes before the first held entry that is not smaller; a full
// table refuses it. A remove takes out the first equal entry, or reports that
// the value is not held. Refused and missed items report slot zero.
// Each item passes the accept, compare and apply steps in turn: the compare
// step lets every cell compare its entry with the value, and in the apply
// step the boundary decode picks the slot and the cells shift toward or
// away from it. The result is registered and appears in the cycle after the
// apply step; a new item is taken only once the previous one is applied.
// A new item is accepted while a result still waits; the shift step then holds
// until the waiting result is taken, so a stalled receiver stalls the block.
// Synchronous reset empties the table at once; no clearing pass is needed.
// ----------------------------------------------------------------------------
module sorted_index_set (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // [15:0] tag_value
  input  logic        s_tuser,   // [0] command
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // [6:0] position, [13:7] entry_count, rest zero
  output logic [1:0]  m_tuser    // [1:0] status
);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_CMP   = 2'd1;
  localparam logic [1:0] S_APPLY = 2'd2;

  logic [1:0]                state;
  logic [1:0]                state_next;
  logic                      cmd;
  sis_pkg::value_t           value;
  logic [sis_pkg::CNT_W-1:0] count;
  logic [sis_pkg::CNT_W-1:0] count_next;
  logic [sis_pkg::CNT_W-1:0] position;
  logic                      found;
  logic                      full;
  logic                      go;
  sis_pkg::cell_ctrl_t       ctrl;
  logic [1:0]                status_next;
  logic [sis_pkg::CNT_W-1:0] pos_next;
  logic [1:0]                out_status;
  logic [sis_pkg::FIELD_W-1:0] out_pos;
  logic [sis_pkg::FIELD_W-1:0] out_count;

  assign s_tready = (state == S_IDLE) && !rst;
  assign full     = (count == sis_pkg::CNT_W'(sis_pkg::DEPTH));
  assign go       = (state == S_APPLY) && (!m_tvalid || m_tready);

  assign ctrl.cmp        = (state == S_CMP);
  assign ctrl.shift_up   = go && (cmd == sis_pkg::CMD_INSERT) && !full;
  assign ctrl.shift_down = go && (cmd == sis_pkg::CMD_REMOVE) && found;

  sis_chain u_chain (
    .clk      (clk),
    .rst      (rst),
    .ctrl     (ctrl),
    .count    (count),
    .value    (value),
    .position (position),
    .found    (found)
  );

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:  if (s_tvalid) state_next = S_CMP;
      S_CMP:   state_next = S_APPLY;
      S_APPLY: if (go) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    count_next  = count;
    status_next = sis_pkg::ST_NOT_FOUND;
    pos_next    = '0;
    if (cmd == sis_pkg::CMD_INSERT) begin
      if (full) begin
        status_next = sis_pkg::ST_FULL;
      end else begin
        status_next = sis_pkg::ST_INSERTED;
        pos_next    = position;
        count_next  = count + 1'b1;
      end
    end else if (found) begin
      status_next = sis_pkg::ST_REMOVED;
      pos_next    = position;
      count_next  = count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      count    <= '0;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (go) begin
        count    <= count_next;
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      cmd   <= s_tuser;
      value <= s_tdata[sis_pkg::VALUE_BITS-1:0];
    end
    if (go) begin
      out_status <= status_next;
      out_pos    <= sis_pkg::FIELD_W'(pos_next);
      out_count  <= sis_pkg::FIELD_W'(count_next);
    end
  end

  assign m_tuser = out_status;
  assign m_tdata = {2'b00, out_count, out_pos};

endmodule

FILE: rtl/sis_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sis_cell
// One slot of the sorted table: holds an entry, compares it against the
// current value and takes the new value or a neighbor's entry when the table shifts.
// ----------------------------------------------------------------------------
module sis_cell (
  input  logic                     clk,
  input  logic                     rst,
  input  sis_pkg::cell_ctrl_t      ctrl,
  input  logic [sis_pkg::IDX_W-1:0] slot,
  input  logic [sis_pkg::CNT_W-1:0] count,
  input  sis_pkg::value_t          value,
  input  logic                     lt_prev,
  input  sis_pkg::value_t          entry_prev,
  input  sis_pkg::value_t          entry_next,
  output logic                     lt,
  output logic                     eq,
  output sis_pkg::value_t          entry
);

  logic in_range;

  assign in_range = ({1'b0, slot} < count);

  always_ff @(posedge clk) begin
    if (rst) begin
      lt <= 1'b0;
      eq <= 1'b0;
    end else if (ctrl.cmp) begin
      lt <= in_range && (entry < value);
      eq <= in_range && (entry == value);
    end
  end

  // Slots before the insert or remove point keep their entry, since the
  // less-than flags form a prefix of the chain.
  always_ff @(posedge clk) begin
    if (ctrl.shift_up && !lt) begin
      entry <= lt_prev ? value : entry_prev;
    end else if (ctrl.shift_down && !lt) begin
      entry <= entry_next;
    end
  end

endmodule

FILE: rtl/sis_chain.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sis_chain
// Row of table cells with the boundary decode that yields the slot of an
// insert or remove and whether a remove found its value.
// ----------------------------------------------------------------------------
module sis_chain (
  input  logic                      clk,
  input  logic                      rst,
  input  sis_pkg::cell_ctrl_t       ctrl,
  input  logic [sis_pkg::CNT_W-1:0] count,
  input  sis_pkg::value_t           value,
  output logic [sis_pkg::CNT_W-1:0] position,
  output logic                      found
);

  logic [sis_pkg::DEPTH-1:0] lt;
  logic [sis_pkg::DEPTH-1:0] eq;
  logic [sis_pkg::DEPTH-1:0] lt_prev;
  logic [sis_pkg::DEPTH-1:0] boundary;
  sis_pkg::value_t           entry [sis_pkg::DEPTH];

  genvar g;
  generate
    for (g = 0; g < sis_pkg::DEPTH; g++) begin : g_cell
      sis_pkg::value_t prev_e;
      sis_pkg::value_t next_e;

      if (g == 0) begin : g_first
        assign lt_prev[g] = 1'b1;
        assign prev_e     = value;
      end else begin : g_mid
        assign lt_prev[g] = lt[g-1];
        assign prev_e     = entry[g-1];
      end

      if (g == sis_pkg::DEPTH - 1) begin : g_last
        assign next_e = entry[g];
      end else begin : g_inner
        assign next_e = entry[g+1];
      end

      assign boundary[g] = lt_prev[g] && !lt[g];

      sis_cell u_cell (
        .clk        (clk),
        .rst        (rst),
        .ctrl       (ctrl),
        .slot       (sis_pkg::IDX_W'(g)),
        .count      (count),
        .value      (value),
        .lt_prev    (lt_prev[g]),
        .entry_prev (prev_e),
        .entry_next (next_e),
        .lt         (lt[g]),
        .eq         (eq[g]),
        .entry      (entry[g])
      );
    end
  endgenerate

  // The boundary is one-hot, at slot count when every held slot is smaller;
  // only a full table of smaller entries leaves it zero, and then position is count.
  always_comb begin
    position = (boundary == '0) ? count : '0;
    for (int i = 0; i < sis_pkg::DEPTH; i++) begin
      if (boundary[i]) begin
        position = position | sis_pkg::CNT_W'(i);
      end
    end
  end

  assign found = |(boundary & eq);

endmodule
